>>> rtl/iprsm_pkg.sv
package iprsm_pkg;

  localparam int MAX_RANGES_DEF = 16;

  localparam logic [7:0] ADDR_BYTES = 8'd16;

  localparam logic [1:0] KIND_CLEAR = 2'd0;
  localparam logic [1:0] KIND_LOAD  = 2'd1;
  localparam logic [1:0] KIND_QUERY = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_LEN     = 2'd2;
  localparam logic [1:0] ST_SUBTYPE = 2'd3;

  localparam int ITEM_DATA_W = 272;
  localparam int RES_DATA_W  = 16;
  localparam int ENTRY_W     = 256;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  byte_count;
    logic [7:0]  value_subtype;
    logic [63:0] mask_lo;
    logic [63:0] mask_hi;
    logic [63:0] addr_lo;
    logic [63:0] addr_hi;
  } item_t;

  typedef struct packed {
    logic [4:0] stored_count;
    logic [1:0] status;
    logic [3:0] match_index;
    logic       matched;
  } res_t;

  typedef enum logic [2:0] {
    FSM_IDLE = 3'b001,
    FSM_SCAN = 3'b010,
    FSM_DONE = 3'b100
  } fsm_t;

endpackage

>>> rtl/ip_range_set_matcher_top.sv
// Table of up to MAX_RANGES 128-bit address ranges held as mask and criterion
// in one table memory. Words are handled one at a time: a clear, a load or a
// query that ends before the table walk goes straight from idle to done; a
// query that walks the table compares one stored entry per cycle through the
// memory's single read port and stops at the first matching entry or after
// the last stored entry. The result sits in an output register, so the next
// word is taken while the previous result waits.
module ip_range_set_matcher_top #(
  parameter int MAX_RANGES = iprsm_pkg::MAX_RANGES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // addr_hi, addr_lo, mask_hi, mask_lo, value_subtype, byte_count
  input  logic [iprsm_pkg::ITEM_DATA_W-1:0]  in_tdata,
  // kind
  input  logic [1:0]                         in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // matched, match_index, status, stored_count, zero fill
  output logic [iprsm_pkg::RES_DATA_W-1:0]   out_tdata
);

  iprsm_pkg::item_t item;
  iprsm_pkg::res_t  res, out_res_r;
  logic             res_valid, slot_free, out_valid_r;

  assign item      = iprsm_pkg::item_t'({in_tuser, in_tdata});
  assign slot_free = !out_valid_r || out_tready;

  iprsm_engine #(
    .MAX_RANGES (MAX_RANGES)
  ) u_engine (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (in_tvalid),
    .item_ready (in_tready),
    .item       (item),
    .slot_free  (slot_free),
    .res_valid  (res_valid),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_valid && slot_free) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && slot_free) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, out_res_r};

endmodule

>>> rtl/iprsm_ram.sv
module iprsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/iprsm_engine.sv
module iprsm_engine #(
  parameter int MAX_RANGES = iprsm_pkg::MAX_RANGES_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             item_valid,
  output logic             item_ready,
  input  iprsm_pkg::item_t item,
  input  logic             slot_free,
  output logic             res_valid,
  output iprsm_pkg::res_t  res
);

  localparam int IDX_W = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int CNT_W = $clog2(MAX_RANGES + 1);

  iprsm_pkg::fsm_t  state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [7:0]       subtype_r, subtype_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [63:0]      q_hi_r, q_hi_nxt;
  logic [63:0]      q_lo_r, q_lo_nxt;
  iprsm_pkg::res_t  res_r, res_nxt;

  logic                          we, re;
  logic [IDX_W-1:0]              waddr, raddr;
  logic [iprsm_pkg::ENTRY_W-1:0] wdata, rdata;
  logic [63:0]                   c_hi, c_lo, m_hi, m_lo;
  logic                          hit, last, len_ok, full;

  iprsm_ram #(
    .WIDTH (iprsm_pkg::ENTRY_W),
    .DEPTH (MAX_RANGES)
  ) u_table (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  // entry layout: crit_hi, crit_lo, mask_hi, mask_lo from the lowest bit up
  assign wdata = {item.mask_lo, item.mask_hi,
                  item.addr_lo & item.mask_lo, item.addr_hi & item.mask_hi};
  assign waddr = IDX_W'(count_r);
  assign {m_lo, m_hi, c_lo, c_hi} = rdata;

  assign hit    = ((q_hi_r & m_hi) == c_hi) && ((q_lo_r & m_lo) == c_lo);
  assign last   = (CNT_W'(idx_r) + CNT_W'(1)) == count_r;
  assign len_ok = item.byte_count == iprsm_pkg::ADDR_BYTES;
  assign full   = count_r == CNT_W'(MAX_RANGES);

  assign item_ready = state_r == iprsm_pkg::FSM_IDLE;
  assign res_valid  = state_r == iprsm_pkg::FSM_DONE;
  assign res        = res_r;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    subtype_nxt = subtype_r;
    idx_nxt     = idx_r;
    q_hi_nxt    = q_hi_r;
    q_lo_nxt    = q_lo_r;
    res_nxt     = res_r;
    we          = 1'b0;
    re          = 1'b0;
    raddr       = '0;
    unique case (state_r)
      iprsm_pkg::FSM_IDLE: begin
        if (item_valid) begin
          state_nxt           = iprsm_pkg::FSM_DONE;
          res_nxt.matched     = 1'b0;
          res_nxt.match_index = '0;
          res_nxt.status      = iprsm_pkg::ST_OK;
          unique case (item.kind)
            iprsm_pkg::KIND_CLEAR: begin
              count_nxt   = '0;
              subtype_nxt = '0;
            end
            iprsm_pkg::KIND_LOAD: begin
              if (!len_ok) begin
                res_nxt.status = iprsm_pkg::ST_LEN;
              end else if (full) begin
                res_nxt.status = iprsm_pkg::ST_FULL;
              end else begin
                we        = 1'b1;
                count_nxt = count_r + CNT_W'(1);
                if (count_r == '0) begin
                  subtype_nxt = item.value_subtype;
                end
              end
            end
            iprsm_pkg::KIND_QUERY: begin
              if (!len_ok) begin
                res_nxt.status = iprsm_pkg::ST_LEN;
              end else if (count_r == '0) begin
                res_nxt.status = iprsm_pkg::ST_OK;
              end else if (item.value_subtype != subtype_r) begin
                res_nxt.status = iprsm_pkg::ST_SUBTYPE;
              end else begin
                re        = 1'b1;
                raddr     = '0;
                idx_nxt   = '0;
                q_hi_nxt  = item.addr_hi;
                q_lo_nxt  = item.addr_lo;
                state_nxt = iprsm_pkg::FSM_SCAN;
              end
            end
            default: begin
            end
          endcase
          res_nxt.stored_count = 5'(count_nxt);
        end
      end
      iprsm_pkg::FSM_SCAN: begin
        if (hit) begin
          res_nxt.matched     = 1'b1;
          res_nxt.match_index = 4'(idx_r);
          res_nxt.status      = iprsm_pkg::ST_OK;
          state_nxt           = iprsm_pkg::FSM_DONE;
        end else if (last) begin
          res_nxt.matched     = 1'b0;
          res_nxt.match_index = '0;
          res_nxt.status      = iprsm_pkg::ST_OK;
          state_nxt           = iprsm_pkg::FSM_DONE;
        end else begin
          re      = 1'b1;
          raddr   = idx_r + IDX_W'(1);
          idx_nxt = idx_r + IDX_W'(1);
        end
        res_nxt.stored_count = 5'(count_r);
      end
      iprsm_pkg::FSM_DONE: begin
        if (slot_free) begin
          state_nxt = iprsm_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_nxt = iprsm_pkg::FSM_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= iprsm_pkg::FSM_IDLE;
      count_r   <= '0;
      subtype_r <= '0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      subtype_r <= subtype_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    q_hi_r <= q_hi_nxt;
    q_lo_r <= q_lo_nxt;
    res_r  <= res_nxt;
  end

endmodule
